### design/cave_rs_pkg.sv
// shared constants and types for the cave automaton row step block
`default_nettype none

package cave_rs_pkg;

    // port widths fixed by the item format
    localparam int ROW_W      = 64;
    localparam int IDX_W      = 10;
    localparam int GW_W       = 7;
    localparam int GH_W       = 11;
    localparam int TH_W       = 4;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    // defaults for the top level parameters
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 1024;

    // the row counter is ten bits, so no frame is taller than this
    localparam int ROW_CAP = 1024;

    // smallest grid side in use
    localparam int MIN_SIDE = 3;

    // register values after reset
    localparam logic [GW_W-1:0] RST_GRID_WIDTH     = GW_W'(10);
    localparam logic [GH_W-1:0] RST_GRID_HEIGHT    = GH_W'(10);
    localparam logic [TH_W-1:0] RST_WALL_THRESHOLD = TH_W'(4);

    // result queue depth, a power of two
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH     = 2'd0,
        CFG_GRID_HEIGHT    = 2'd1,
        CFG_WALL_THRESHOLD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

endpackage

`default_nettype wire

### design/cave_rs_lane.sv
// one column lane: counts the eight neighbour walls and compares with the threshold
`default_nettype none

module cave_rs_lane (
    input  wire logic [2:0]                     i_up,
    input  wire logic [1:0]                     i_mid,
    input  wire logic [2:0]                     i_down,
    input  wire logic [cave_rs_pkg::TH_W-1:0]   i_threshold,
    output logic                                o_wall
);

    logic [3:0] w_count;

    always_comb begin
        w_count = 4'(i_up[0]) + 4'(i_up[1]) + 4'(i_up[2])
                + 4'(i_mid[0]) + 4'(i_mid[1])
                + 4'(i_down[0]) + 4'(i_down[1]) + 4'(i_down[2]);
        o_wall  = (w_count >= i_threshold);
    end

endmodule

`default_nettype wire

### design/cave_rs_merge.sv
// merging stage: joins lane decisions into a row, forces the border and masks to width
`default_nettype none

module cave_rs_merge #(
    parameter int MAX_WIDTH = cave_rs_pkg::DEF_MAX_WIDTH
) (
    input  wire logic [MAX_WIDTH-1:0]          i_lane_wall,
    input  wire logic [cave_rs_pkg::GW_W-1:0]  i_width,
    output logic      [MAX_WIDTH-1:0]          o_row,
    output logic      [MAX_WIDTH-1:0]          o_mask
);

    logic [cave_rs_pkg::GW_W-1:0] w_last_col;

    // the mask depends on the width alone, the lanes read it through the current row
    always_comb begin
        for (int c = 0; c < MAX_WIDTH; c++) begin
            o_mask[c] = (cave_rs_pkg::GW_W'(c) < i_width);
        end
    end

    always_comb begin
        w_last_col = i_width - cave_rs_pkg::GW_W'(1);
        for (int c = 0; c < MAX_WIDTH; c++) begin
            if (c == 0 || cave_rs_pkg::GW_W'(c) == w_last_col) begin
                o_row[c] = o_mask[c];
            end else begin
                o_row[c] = o_mask[c] & i_lane_wall[c];
            end
        end
    end

endmodule

`default_nettype wire

### design/cave_rs_queue.sv
// small result queue: takes up to two results a cycle, hands out one
`default_nettype none

module cave_rs_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cave_rs_pkg::t_push    i_push0,
    input  wire cave_rs_pkg::t_push    i_push1,
    input  wire logic                  i_pop,
    output cave_rs_pkg::t_result       o_head,
    output logic                       o_valid,
    output logic                       o_room2
);

    localparam int DEPTH = cave_rs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cave_rs_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       w_npush;

    always_comb begin
        w_npush = 2'(i_push0.valid) + 2'(i_push1.valid);
        n_wr    = r_wr + PTR_W'(w_npush);
        n_rd    = r_rd + PTR_W'(i_pop);
        n_count = r_count + CNT_W'(w_npush) - CNT_W'(i_pop);
        o_valid = (r_count != '0);
        o_room2 = (r_count <= CNT_W'(DEPTH - 2));
        o_head  = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0.valid) begin
            r_mem[r_wr] <= i_push0.res;
        end
        if (i_push1.valid) begin
            r_mem[r_wr + PTR_W'(1)] <= i_push1.res;
        end
    end

endmodule

`default_nettype wire

### design/cave_automaton_row_step.sv
// top level of the cave automaton row step: row store, column lanes, merge and result queue
//
// Rows of the old generation come in one item per cycle, while o_in_stall is low,
// on the input channel (i_in_valid / o_in_stall); bit c of i_row_cells is column c,
// 1 is wall, and i_frame_start marks row 0 of a frame. Rows of the new generation
// leave on the output channel (o_out_valid / i_out_stall) with their index and a
// last-row flag. Each output row is ready once the row below it has arrived, so
// results lag the input by one row; the last row of a frame yields two results.
// A result sits in the output queue in the cycle after the item that completes
// it is accepted. All column lanes work on a row at once, so the rate is set only
// by the single-result output port, which hands out the two results of a frame's
// last row one after the other. A four-entry result queue sits between the sides;
// the input stalls while it has room for fewer than two results, so an item is
// taken while earlier results still wait to be taken. When the receiver stalls,
// the head result holds until taken. Reset (synchronous, active low) empties the
// queue, clears the stored rows and row count and loads the registers with width
// 10, height 10, threshold 4. Registers are written through i_cfg_we, i_cfg_index and
// i_cfg_wdata; the user must write them only while idle, which the block itself does
// not enforce.
`default_nettype none

module cave_automaton_row_step #(
    parameter int MAX_WIDTH  = cave_rs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cave_rs_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [cave_rs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [cave_rs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [cave_rs_pkg::ROW_W-1:0]       i_row_cells,
    input  wire logic                                i_frame_start,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic      [cave_rs_pkg::ROW_W-1:0]       o_new_row_cells,
    output logic      [cave_rs_pkg::IDX_W-1:0]       o_row_index,
    output logic                                     o_frame_last
);

    localparam int GW_W    = cave_rs_pkg::GW_W;
    localparam int GH_W    = cave_rs_pkg::GH_W;
    localparam int TH_W    = cave_rs_pkg::TH_W;
    localparam int IDX_W   = cave_rs_pkg::IDX_W;
    localparam int ROW_W   = cave_rs_pkg::ROW_W;
    localparam int H_CAP   = (MAX_HEIGHT > cave_rs_pkg::ROW_CAP) ?
                             cave_rs_pkg::ROW_CAP : MAX_HEIGHT;

    logic [GW_W-1:0]      r_grid_width;
    logic [GH_W-1:0]      r_grid_height;
    logic [TH_W-1:0]      r_wall_threshold;
    logic [MAX_WIDTH-1:0] r_older, r_newer;
    logic [IDX_W-1:0]     r_rows_seen, n_rows_seen;

    logic [GW_W-1:0]      w_width;
    logic [GH_W-1:0]      w_height;
    logic [MAX_WIDTH-1:0] w_mask, w_cur, w_lane_wall, w_merged;
    logic [MAX_WIDTH+1:0] w_up_pad, w_mid_pad, w_down_pad;
    logic [IDX_W-1:0]     w_r, w_idx;
    logic                 w_in_acc, w_emit_int, w_emit_last, w_out_acc;
    logic                 w_room2;

    cave_rs_pkg::t_result w_int_res, w_last_res, w_head;
    cave_rs_pkg::t_push   w_push0, w_push1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width     <= cave_rs_pkg::RST_GRID_WIDTH;
            r_grid_height    <= cave_rs_pkg::RST_GRID_HEIGHT;
            r_wall_threshold <= cave_rs_pkg::RST_WALL_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (cave_rs_pkg::t_cfg_idx'(i_cfg_index))
                cave_rs_pkg::CFG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_wdata[GW_W-1:0];
                end
                cave_rs_pkg::CFG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_wdata[GH_W-1:0];
                end
                cave_rs_pkg::CFG_WALL_THRESHOLD: begin
                    r_wall_threshold <= i_cfg_wdata[TH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp width and height to the range in use
    always_comb begin
        if (r_grid_width < GW_W'(cave_rs_pkg::MIN_SIDE)) begin
            w_width = GW_W'(cave_rs_pkg::MIN_SIDE);
        end else if (r_grid_width > GW_W'(MAX_WIDTH)) begin
            w_width = GW_W'(MAX_WIDTH);
        end else begin
            w_width = r_grid_width;
        end
        if (r_grid_height < GH_W'(cave_rs_pkg::MIN_SIDE)) begin
            w_height = GH_W'(cave_rs_pkg::MIN_SIDE);
        end else if (r_grid_height > GH_W'(H_CAP)) begin
            w_height = GH_W'(H_CAP);
        end else begin
            w_height = r_grid_height;
        end
    end

    always_comb begin
        w_cur      = i_row_cells[MAX_WIDTH-1:0] & w_mask;
        w_up_pad   = {1'b0, r_older, 1'b0};
        w_mid_pad  = {1'b0, r_newer, 1'b0};
        w_down_pad = {1'b0, w_cur, 1'b0};
    end

    // one lane per column, padded with floor past both edges
    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_lane
        cave_rs_lane u_lane (
            .i_up        (w_up_pad[c+2:c]),
            .i_mid       ({w_mid_pad[c+2], w_mid_pad[c]}),
            .i_down      (w_down_pad[c+2:c]),
            .i_threshold (r_wall_threshold),
            .o_wall      (w_lane_wall[c])
        );
    end

    cave_rs_merge #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_merge (
        .i_lane_wall (w_lane_wall),
        .i_width     (w_width),
        .o_row       (w_merged),
        .o_mask      (w_mask)
    );

    always_comb begin
        w_in_acc    = i_in_valid && !o_in_stall;
        w_r         = i_frame_start ? '0 : r_rows_seen;
        w_idx       = w_r - IDX_W'(1);
        w_emit_int  = (w_r != '0);
        w_emit_last = ({1'b0, w_r} + GH_W'(1)) >= w_height;
        n_rows_seen = w_emit_last ? '0 : (w_r + IDX_W'(1));

        // top row of the frame is all wall
        w_int_res.row  = ROW_W'((w_idx == '0) ? w_mask : w_merged);
        w_int_res.idx  = w_idx;
        w_int_res.last = 1'b0;

        w_last_res.row  = ROW_W'(w_mask);
        w_last_res.idx  = w_r;
        w_last_res.last = 1'b1;

        if (w_emit_int) begin
            w_push0.valid = w_in_acc;
            w_push0.res   = w_int_res;
            w_push1.valid = w_in_acc && w_emit_last;
            w_push1.res   = w_last_res;
        end else begin
            w_push0.valid = w_in_acc && w_emit_last;
            w_push0.res   = w_last_res;
            w_push1.valid = 1'b0;
            w_push1.res   = w_last_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older     <= '0;
            r_newer     <= '0;
            r_rows_seen <= '0;
        end else if (w_in_acc) begin
            r_older     <= r_newer;
            r_newer     <= w_cur;
            r_rows_seen <= n_rows_seen;
        end
    end

    cave_rs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_push0),
        .i_push1 (w_push1),
        .i_pop   (w_out_acc),
        .o_head  (w_head),
        .o_valid (o_out_valid),
        .o_room2 (w_room2)
    );

    always_comb begin
        o_in_stall      = !w_room2;
        w_out_acc       = o_out_valid && !i_out_stall;
        o_new_row_cells = w_head.row;
        o_row_index     = w_head.idx;
        o_frame_last    = w_head.last;
    end

    // a frame start always leaves the count at one, since frames are at least three rows
    a_frame_start_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_frame_start) |=> (r_rows_seen == IDX_W'(1)))
        else $error("row count not one after frame start");

    // any row past the first of a frame leaves a result waiting
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_frame_start && r_rows_seen != '0) |=> o_out_valid)
        else $error("no result after a non-first row");

    // the last row of a frame goes on push0 only when no row before it is pushed, so it never goes ahead of that row
    a_last_pushed_with_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push0.valid && w_push0.res.last) |-> !w_emit_int)
        else $error("last row pushed ahead of the row before it");

endmodule

`default_nettype wire
